FILE: hdl/i2csram_pkg.sv
// Shared constants, codes and controller/datapath interface types for the I2C SRAM emulator.
package i2csram_pkg;

   // Memory geometry and control slot location
   localparam int MEM_SIZE   = 4100;
   localparam int CTRL_INDEX = 4096;

   localparam int ADDR_W = 16;                    // two-byte address from the master
   localparam int IDX_W  = $clog2(MEM_SIZE);      // memory index
   localparam int PTR_W  = $clog2(MEM_SIZE + 1);  // pointer also holds MEM_SIZE

   // Control byte and its two mirror slots; a slot past the end never exists
   localparam bit CTRL0_LIVE = (CTRL_INDEX < MEM_SIZE);
   localparam bit CTRL1_LIVE = (CTRL_INDEX + 1 < MEM_SIZE);
   localparam bit CTRL2_LIVE = (CTRL_INDEX + 2 < MEM_SIZE);

   typedef enum logic [1:0] {
      MODE_WR_START = 2'd0,
      MODE_RX_DATA  = 2'd1,
      MODE_TX_REQ   = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;   // zero one memory entry
      logic start;        // request accepted this edge
      logic finish;       // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;   // last entry of the clearing pass
   } status_type;

endpackage

FILE: hdl/i2c_slave_sram_emulator.sv
// Top level of the I2C slave SRAM emulator: controller plus datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_mode[1:0], req_rx_byte[7:0]
//   rsp_      out        rsp_valid/rsp_stall  rsp_tx_byte[7:0], rsp_gpio_zero, rsp_gpio_one
//
// Each request passes from accept through a wait state, set by the registered read
// port of the byte memory, into the result register; one request is in flight at a time.
// After reset the memory is zeroed by a clearing pass over all MEM_SIZE entries
// (4100); req_stall stays high during that pass.
// Reset is synchronous, active high.
// A stalled result holds in the output register; a new request is taken
// in the cycle the waiting result leaves.
module i2c_slave_sram_emulator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_gpio_zero,
   output logic       rsp_gpio_one
);
   import i2csram_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: clear pass, accept, memory read wait, result load
   i2csram_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // memory, pointer, address capture, control byte mirror, result register
   i2csram_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_mode),
      .req_rx_byte   (req_rx_byte),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_gpio_zero (rsp_gpio_zero),
      .rsp_gpio_one  (rsp_gpio_one)
   );

   // an accepted request keeps the input side closed while it is in the wait state
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in work");

   // every accepted request yields a result after the wait state
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("result missing after accepted request");

   // nothing moves while the memory is being cleared
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> req_stall && !rsp_valid)
      else $error("traffic during clearing pass");

endmodule

FILE: hdl/i2csram_ctrl.sv
// Sequencing state machine: clearing pass, request accept, result handoff.
module i2csram_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2csram_pkg::cmd_type    cmd,
   input  i2csram_pkg::status_type status
);
   import i2csram_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // result register is free if empty or being taken this edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.start      = (state_ff == ST_IDLE) && req_valid && out_free;
      cmd.finish     = (state_ff == ST_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (cmd.start) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_CLEAR;
         endcase

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: hdl/i2csram_dp.sv
// Datapath: byte memory, address pointer, address capture, control byte and result register.
module i2csram_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  i2csram_pkg::cmd_type    cmd,
   output i2csram_pkg::status_type status,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_rx_byte,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_gpio_zero,
   output logic                    rsp_gpio_one
);
   import i2csram_pkg::*;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_MEM,
      SEL_CTRL1,
      SEL_CTRL2
   } sel_type;

   localparam logic [PTR_W-1:0]  MEM_END   = PTR_W'(MEM_SIZE);
   localparam logic [PTR_W:0]    MEM_END_X = (PTR_W + 1)'(MEM_SIZE);
   localparam logic [ADDR_W-1:0] MEM_END_A = ADDR_W'(MEM_SIZE);
   localparam logic [PTR_W-1:0]  CTRL0_P   = PTR_W'(CTRL_INDEX);
   localparam logic [PTR_W-1:0]  CTRL1_P   = PTR_W'(CTRL_INDEX + 1);
   localparam logic [PTR_W-1:0]  CTRL2_P   = PTR_W'(CTRL_INDEX + 2);
   localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(MEM_SIZE - 1);

   logic [7:0]        mem [MEM_SIZE];

   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              phase_ff, phase_in;     // capturing address bytes
   logic              seen_ff, seen_in;       // high address byte taken
   logic [7:0]        ctrl_ff, ctrl_in;       // copy of the control byte
   logic [IDX_W-1:0]  clr_ff;
   sel_type           sel_ff, sel_in;
   logic [7:0]        rd_ff;
   logic [7:0]        tx_ff;
   logic              gpio0_ff, gpio1_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [7:0]        wr_data;
   logic              ptr_live;
   logic [PTR_W:0]    ptr_inc;
   logic [PTR_W-1:0]  ptr_adv;
   logic [ADDR_W-1:0] addr_hi, addr_lo;
   logic [PTR_W-1:0]  clamp_hi, clamp_lo;

   assign ptr_live = (ptr_ff < MEM_END);
   assign ptr_inc  = {1'b0, ptr_ff} + (PTR_W + 1)'(1);
   assign ptr_adv  = (ptr_inc >= MEM_END_X) ? '0 : ptr_inc[PTR_W-1:0];

   assign addr_hi  = {req_rx_byte, 8'h00};
   assign addr_lo  = ADDR_W'(ptr_ff) | ADDR_W'(req_rx_byte);
   assign clamp_hi = (addr_hi >= MEM_END_A) ? MEM_END : addr_hi[PTR_W-1:0];
   assign clamp_lo = (addr_lo >= MEM_END_A) ? MEM_END : addr_lo[PTR_W-1:0];

   assign status.clear_last = (clr_ff == CLR_LAST);

   always_comb begin
      ptr_in   = ptr_ff;
      phase_in = phase_ff;
      seen_in  = seen_ff;
      ctrl_in  = ctrl_ff;
      sel_in   = sel_ff;
      wr_en    = 1'b0;
      wr_idx   = ptr_ff[IDX_W-1:0];
      wr_data  = req_rx_byte;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_idx  = clr_ff;
         wr_data = 8'h00;
      end else if (cmd.start) begin
         sel_in = SEL_ZERO;
         unique case (mode_type'(req_mode))
            MODE_TX_REQ: begin
               // mirror slots always read as the live control bits
               if (!ptr_live) sel_in = SEL_ZERO;
               else if (CTRL1_LIVE && ptr_ff == CTRL1_P) sel_in = SEL_CTRL1;
               else if (CTRL2_LIVE && ptr_ff == CTRL2_P) sel_in = SEL_CTRL2;
               else sel_in = SEL_MEM;
               ptr_in = ptr_adv;
            end
            MODE_WR_START: begin
               phase_in = 1'b1;
               seen_in  = 1'b0;
            end
            MODE_RX_DATA: begin
               if (phase_ff) begin
                  if (!seen_ff) begin
                     ptr_in  = clamp_hi;
                     seen_in = 1'b1;
                  end else begin
                     ptr_in   = clamp_lo;
                     seen_in  = 1'b0;
                     phase_in = 1'b0;
                  end
               end else begin
                  wr_en = ptr_live;
                  if (CTRL0_LIVE && ptr_ff == CTRL0_P) ctrl_in = req_rx_byte;
                  ptr_in = ptr_adv;
               end
            end
            MODE_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         phase_ff <= 1'b1;
         seen_ff  <= 1'b0;
         ctrl_ff  <= 8'h00;
         clr_ff   <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         ctrl_ff  <= ctrl_in;
         if (cmd.clear_step) clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) rd_ff <= mem[ptr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (cmd.finish) begin
         unique case (sel_ff)
            SEL_ZERO:  tx_ff <= 8'h00;
            SEL_MEM:   tx_ff <= rd_ff;
            SEL_CTRL1: tx_ff <= {7'd0, ctrl_ff[0]};
            SEL_CTRL2: tx_ff <= {7'd0, ctrl_ff[1]};
            default:   tx_ff <= 8'h00;
         endcase
         gpio0_ff <= CTRL1_LIVE && ctrl_ff[0];
         gpio1_ff <= CTRL2_LIVE && ctrl_ff[1];
      end
   end

   assign rsp_tx_byte   = tx_ff;
   assign rsp_gpio_zero = gpio0_ff;
   assign rsp_gpio_one  = gpio1_ff;

endmodule
